FILE: sv/sle_pkg.sv
// Package with the shared constants, command and status codes and cell control type.
`default_nettype none
package sle_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KEY_W  = 32;
  localparam int CMD_W  = 2;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;
  localparam int FILL_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // Control that the top level hands to one cell of the chain.
  typedef struct packed {
    logic             ins;       // an accepted insert that will succeed
    logic             rem;       // an accepted remove that will succeed
    logic [KEY_W-1:0] key;       // key being inserted
    logic             occupied;  // the cell sits below the current count
    logic             head;      // the cell is the first one of the chain
    logic             rm_here;   // the cell sits at or above the remove index
  } cell_ctl_t;

endpackage
`default_nettype wire

FILE: sv/sle_cell.sv
// One storage cell of the sorted chain: holds a key and shifts with its neighbors.
`default_nettype none
module sle_cell (
  input  wire logic                       clk,
  input  wire sle_pkg::cell_ctl_t         ctl,
  input  wire logic                       left_geq,
  input  wire logic [sle_pkg::KEY_W-1:0]  left_entry,
  input  wire logic [sle_pkg::KEY_W-1:0]  right_entry,
  output logic                            geq,
  output logic [sle_pkg::KEY_W-1:0]       entry
);

  logic [sle_pkg::KEY_W-1:0] entry_r;
  logic [sle_pkg::KEY_W-1:0] entry_nxt;
  logic                      entry_lt_key;
  logic                      key_lt_entry;

  assign entry_lt_key = $signed(entry_r) < $signed(ctl.key);
  assign key_lt_entry = $signed(ctl.key) < $signed(entry_r);

  // The head only gives way to a strictly smaller key; the others to any key
  // that is not larger than theirs. An empty cell always lies past the slot.
  always_comb begin
    if (ctl.head) begin
      geq = !ctl.occupied || key_lt_entry;
    end else begin
      geq = !ctl.occupied || !entry_lt_key;
    end
  end

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (left_geq && !ctl.head) begin
        entry_nxt = left_entry;
      end else if (geq) begin
        entry_nxt = ctl.key;
      end
    end else if (ctl.rem && ctl.rm_here) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule
`default_nettype wire

FILE: sv/sorted_list_engine_core.sv
// Top level of the sorted list engine: command decode, cell chain and result register.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_cmd, in_key_in, in_position
//   out_     output     out_valid/out_stall out_status, out_key_out, out_fill
//
// One command word is taken per cycle while in_stall is low; its result word appears in the next cycle.
// The rate is set by the cell chain, where each cell does one key compare and
// decides on its own whether to hold, take the new key or take a neighbor's key.
// Reset (rst_n low at a clock edge) empties the list; the cell keys are not cleared.
// When a result waits with out_stall high, in_stall rises and no command is taken.
`default_nettype none
module sorted_list_engine_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [sle_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic signed [sle_pkg::KEY_W-1:0] in_key_in,
  input  wire logic [sle_pkg::POS_W-1:0]     in_position,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [sle_pkg::STAT_W-1:0]         out_status,
  output logic signed [sle_pkg::KEY_W-1:0]   out_key_out,
  output logic [sle_pkg::FILL_W-1:0]         out_fill
);

  logic [sle_pkg::CNT_W-1:0]  count_r;
  logic [sle_pkg::CNT_W-1:0]  count_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [sle_pkg::STAT_W-1:0] out_status_r;
  logic [sle_pkg::STAT_W-1:0] out_status_nxt;
  logic [sle_pkg::KEY_W-1:0]  out_key_r;
  logic [sle_pkg::KEY_W-1:0]  out_key_nxt;
  logic [sle_pkg::FILL_W-1:0] out_fill_r;

  logic accept;
  logic full;
  logic pos_in_range;
  logic ins_ok;
  logic rem_ok;
  logic rd_ok;
  logic [sle_pkg::KEY_W-1:0] read_key;

  sle_pkg::cell_ctl_t        cell_ctl  [sle_pkg::DEPTH];
  logic                      cell_geq  [sle_pkg::DEPTH];
  logic [sle_pkg::KEY_W-1:0] cell_key  [sle_pkg::DEPTH];

  // A finished result may sit in the output register while out_stall is high;
  // only then is the input held off.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full         = count_r == sle_pkg::CNT_W'(sle_pkg::DEPTH);
  assign pos_in_range = 32'(in_position) < 32'(count_r);

  assign ins_ok = accept && (in_cmd == sle_pkg::CMD_INSERT) && !full;
  assign rem_ok = accept && (in_cmd == sle_pkg::CMD_REMOVE) && pos_in_range;
  assign rd_ok  = (in_cmd == sle_pkg::CMD_READ) && pos_in_range;

  // The chain. Each cell sees its left neighbor's compare result and both
  // neighbors' keys, so an insert opens a gap at the slot and a remove closes
  // the gap at the index.
  for (genvar i = 0; i < sle_pkg::DEPTH; i++) begin : g_cell
    assign cell_ctl[i].ins      = ins_ok;
    assign cell_ctl[i].rem      = rem_ok;
    assign cell_ctl[i].key      = in_key_in;
    assign cell_ctl[i].occupied = 32'(i) < 32'(count_r);
    assign cell_ctl[i].head     = (i == 0);
    assign cell_ctl[i].rm_here  = 32'(i) >= 32'(in_position);

    sle_cell u_cell (
      .clk         (clk),
      .ctl         (cell_ctl[i]),
      .left_geq    ((i == 0) ? 1'b0 : cell_geq[(i == 0) ? 0 : i - 1]),
      .left_entry  ((i == 0) ? in_key_in : cell_key[(i == 0) ? 0 : i - 1]),
      .right_entry ((i == sle_pkg::DEPTH - 1) ? cell_key[i]
                    : cell_key[(i == sle_pkg::DEPTH - 1) ? i : i + 1]),
      .geq         (cell_geq[i]),
      .entry       (cell_key[i])
    );
  end

  // Read port: every cell compares its own place with the position and the
  // selected key is gathered with an OR.
  always_comb begin
    read_key = '0;
    for (int i = 0; i < sle_pkg::DEPTH; i++) begin
      if (32'(in_position) == 32'(i)) begin
        read_key = read_key | cell_key[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + sle_pkg::CNT_W'(1);
    end else if (rem_ok) begin
      count_nxt = count_r - sle_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    case (in_cmd)
      sle_pkg::CMD_INSERT: begin
        out_status_nxt = full ? sle_pkg::ST_FULL : sle_pkg::ST_OK;
      end
      sle_pkg::CMD_REMOVE, sle_pkg::CMD_READ: begin
        out_status_nxt = pos_in_range ? sle_pkg::ST_OK : sle_pkg::ST_BOUNDS;
      end
      default: begin
        out_status_nxt = sle_pkg::ST_BOUNDS;
      end
    endcase
    out_key_nxt = rd_ok ? read_key : '0;
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The result payload loads only with an accepted command, so it holds while
  // the word waits under out_stall.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= out_status_nxt;
      out_key_r    <= out_key_nxt;
      out_fill_r   <= sle_pkg::FILL_W'(count_nxt);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_key_out = out_key_r;
  assign out_fill    = out_fill_r;

endmodule
`default_nettype wire

FILE: sv/sle_checker.sv
// Port-level checker for the sorted list engine and its bind to the top level.
`default_nettype none
module sle_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic [sle_pkg::STAT_W-1:0]         out_status,
  input wire logic signed [sle_pkg::KEY_W-1:0]   out_key_out,
  input wire logic [sle_pkg::FILL_W-1:0]         out_fill
);

  // The input is only held off while a result word is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall high without a waiting result word");

  // Every accepted command word is answered in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted command word without a result word");

  // A waiting result word keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)
                                  && $stable(out_key_out) && $stable(out_fill)))
    else $error("result word changed while stalled");

  // A refused insert only happens on a full list.
  a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == sle_pkg::ST_FULL)
      |-> (out_fill == sle_pkg::FILL_W'(sle_pkg::DEPTH)))
    else $error("full status with a list that is not full");

  // A key is only reported by a successful command on a non-empty list.
  a_key_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_key_out != '0)
      |-> (out_status == sle_pkg::ST_OK && out_fill != '0))
    else $error("key reported without a successful read");

endmodule

bind sorted_list_engine_core sle_checker u_sle_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_status  (out_status),
  .out_key_out (out_key_out),
  .out_fill    (out_fill)
);
`default_nettype wire
